[hw/rtl/httprl_pkg.sv]
// ----------------------------------------------------------------------------
// httprl_pkg
// Shared codes, string tables and helpers for the HTTP request line parser.
// ----------------------------------------------------------------------------
package httprl_pkg;

    localparam int DEFAULT_LENGTH_BITS = 16;
    localparam int NUM_METHODS         = 7;
    localparam int NUM_VERSIONS        = 2;
    localparam int METHOD_CHARS        = 7;
    localparam int VERSION_CHARS       = 8;
    localparam int OUT_LENGTH_BITS     = 16;

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Byte classes
    localparam logic [2:0] CLASS_METHOD   = 3'd0;
    localparam logic [2:0] CLASS_SPACE    = 3'd1;
    localparam logic [2:0] CLASS_PATH     = 3'd2;
    localparam logic [2:0] CLASS_QMARK    = 3'd3;
    localparam logic [2:0] CLASS_QUERY    = 3'd4;
    localparam logic [2:0] CLASS_VERSION  = 3'd5;

    localparam logic [2:0] METHOD_INVALID = 3'd0;
    localparam logic [1:0] VERSION_INVALID = 2'd0;
    localparam logic [1:0] VERSION_1_0     = 2'd1;
    localparam logic [1:0] VERSION_1_1     = 2'd2;

    localparam logic [3:0] POSITION_MAX    = 4'd15;
    localparam logic [3:0] VERSION_LEN     = 4'd8;

    // Method names, left-justified, padded; padding is never compared.
    localparam logic [8*METHOD_CHARS-1:0] METHOD_NAME [NUM_METHODS] = '{
        "GET    ", "POST   ", "PUT    ", "DELETE ", "HEAD   ", "OPTIONS", "PATCH  "
    };
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5
    };
    // Candidate 0 is HTTP/1.0, candidate 1 is HTTP/1.1.
    localparam logic [8*VERSION_CHARS-1:0] VERSION_NAME [NUM_VERSIONS] = '{
        "HTTP/1.0", "HTTP/1.1"
    };

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic is_lower;
        is_lower = (b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z);
        return is_lower ? (b - CASE_OFFSET) : b;
    endfunction

    function automatic logic [7:0] method_char(input int k, input logic [3:0] p);
        int pi;
        pi = int'(p);
        if (pi < METHOD_CHARS)
            return METHOD_NAME[k][8*(METHOD_CHARS-1-pi) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] version_char(input int k, input logic [3:0] p);
        int pi;
        pi = int'(p);
        if (pi < VERSION_CHARS)
            return VERSION_NAME[k][8*(VERSION_CHARS-1-pi) +: 8];
        return 8'h00;
    endfunction

endpackage

[hw/rtl/http_request_line_parser_top.sv]
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Classifies the bytes of one HTTP request line and reports its verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel line_valid/line_ready carries one byte of a request line
//   (CRLF removed) per transaction, with line_last on the final byte.
//   Output channel result_valid/result_ready returns one transaction per input
//   byte: the echoed byte, its class, and on the final byte (line_done) the
//   method and version codes, line_ok and the saturating URL/path lengths.
//   The result is registered: the parse state and the result register are both
//   updated at the input handshake. Throughput is one byte per cycle when
//   result_ready is high; the single result register sets that figure, and a
//   new byte is taken in the same cycle the held result is taken.
//   When the receiver stalls, the result holds and line_ready drops until the
//   result is taken. Reset clears the parse state and empties the result
//   register; the parse state also returns to its reset values after every
//   final byte, so lines follow each other with no gap.
// ----------------------------------------------------------------------------
module http_request_line_parser_top
    import httprl_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_valid,
    output logic        line_ready,
    input  logic [7:0]  line_byte,
    input  logic        line_last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  echo_byte,
    output logic [2:0]  byte_class,
    output logic        line_done,
    output logic [2:0]  method_code,
    output logic [1:0]  version_code,
    output logic        line_ok,
    output logic [15:0] url_length,
    output logic [15:0] path_length
);

    typedef enum logic [1:0] {
        PHASE_METHOD  = 2'd0,
        PHASE_URL     = 2'd1,
        PHASE_VERSION = 2'd2
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0] OUT_MAX = 32'((64'd1 << OUT_LENGTH_BITS) - 64'd1);

    phase_t                  phase_reg, phase_next;
    logic [3:0]              method_pos_reg, method_pos_next;
    logic [NUM_METHODS-1:0]  method_cand_reg, method_cand_next;
    logic                    in_query_reg, in_query_next;
    logic [LENGTH_BITS-1:0]  url_count_reg, url_count_next;
    logic [LENGTH_BITS-1:0]  path_count_reg, path_count_next;
    logic [3:0]              version_pos_reg, version_pos_next;
    logic [NUM_VERSIONS-1:0] version_cand_reg, version_cand_next;

    logic        result_valid_reg;
    logic [7:0]  echo_byte_reg;
    logic [2:0]  byte_class_reg, byte_class_next;
    logic        line_done_reg;
    logic [2:0]  method_code_reg, method_code_next;
    logic [1:0]  version_code_reg, version_code_next;
    logic        line_ok_reg, line_ok_next;
    logic [15:0] url_length_reg, url_length_next;
    logic [15:0] path_length_reg, path_length_next;

    logic [7:0]  upper_byte;
    logic        is_space;
    logic        accept;
    logic [2:0]  first_method;
    logic [31:0] url_wide;
    logic [31:0] path_wide;

    assign line_ready = !result_valid_reg || result_ready;
    assign accept     = line_valid && line_ready;
    assign upper_byte = fold_upper(line_byte);
    assign is_space   = (line_byte == CHAR_SPACE);

    // Next parse state for the byte on the input port
    always_comb
    begin
        phase_next        = phase_reg;
        method_pos_next   = method_pos_reg;
        method_cand_next  = method_cand_reg;
        in_query_next     = in_query_reg;
        url_count_next    = url_count_reg;
        path_count_next   = path_count_reg;
        version_pos_next  = version_pos_reg;
        version_cand_next = version_cand_reg;
        byte_class_next   = CLASS_METHOD;
        unique case (phase_reg)
            PHASE_METHOD:
            begin
                if (is_space)
                begin
                    // keep only methods whose length matches what was seen
                    for (int k = 0; k < NUM_METHODS; k++)
                        if (METHOD_LEN[k] != method_pos_reg)
                            method_cand_next[k] = 1'b0;
                    phase_next      = PHASE_URL;
                    byte_class_next = CLASS_SPACE;
                end
                else
                begin
                    for (int k = 0; k < NUM_METHODS; k++)
                        if (method_pos_reg >= METHOD_LEN[k] ||
                            method_char(k, method_pos_reg) != upper_byte)
                            method_cand_next[k] = 1'b0;
                    if (method_pos_reg < POSITION_MAX)
                        method_pos_next = method_pos_reg + 4'd1;
                    byte_class_next = CLASS_METHOD;
                end
            end
            PHASE_URL:
            begin
                if (is_space)
                begin
                    phase_next      = PHASE_VERSION;
                    byte_class_next = CLASS_SPACE;
                end
                else
                begin
                    if (url_count_reg != COUNT_MAX)
                        url_count_next = url_count_reg + 1'b1;
                    if (in_query_reg)
                        byte_class_next = CLASS_QUERY;
                    else if (line_byte == CHAR_QUESTION)
                    begin
                        in_query_next   = 1'b1;
                        byte_class_next = CLASS_QMARK;
                    end
                    else
                    begin
                        if (path_count_reg != COUNT_MAX)
                            path_count_next = path_count_reg + 1'b1;
                        byte_class_next = CLASS_PATH;
                    end
                end
            end
            default:
            begin
                // version phase; later spaces belong to the version too
                for (int k = 0; k < NUM_VERSIONS; k++)
                    if (version_pos_reg >= VERSION_LEN ||
                        version_char(k, version_pos_reg) != upper_byte)
                        version_cand_next[k] = 1'b0;
                if (version_pos_reg < POSITION_MAX)
                    version_pos_next = version_pos_reg + 4'd1;
                byte_class_next = CLASS_VERSION;
            end
        endcase
    end

    // Verdict from the updated state
    always_comb
    begin
        first_method = METHOD_INVALID;
        for (int k = NUM_METHODS - 1; k >= 0; k--)
            if (method_cand_next[k])
                first_method = 3'(k + 1);

        url_wide  = 32'(url_count_next);
        path_wide = 32'(path_count_next);

        method_code_next  = METHOD_INVALID;
        version_code_next = VERSION_INVALID;
        line_ok_next      = 1'b0;
        url_length_next   = '0;
        path_length_next  = '0;
        if (line_last && phase_next == PHASE_VERSION)
        begin
            method_code_next = first_method;
            if (version_pos_next == VERSION_LEN)
            begin
                priority if (version_cand_next[1])
                    version_code_next = VERSION_1_1;
                else if (version_cand_next[0])
                    version_code_next = VERSION_1_0;
                else
                    version_code_next = VERSION_INVALID;
            end
            line_ok_next    = (method_code_next != METHOD_INVALID) &&
                              (version_code_next != VERSION_INVALID);
            url_length_next = (url_wide > OUT_MAX) ? 16'hFFFF : url_wide[15:0];
            path_length_next = (path_wide > OUT_MAX) ? 16'hFFFF : path_wide[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PHASE_METHOD;
            method_pos_reg   <= '0;
            method_cand_reg  <= '1;
            in_query_reg     <= 1'b0;
            url_count_reg    <= '0;
            path_count_reg   <= '0;
            version_pos_reg  <= '0;
            version_cand_reg <= '1;
            result_valid_reg <= 1'b0;
            echo_byte_reg    <= '0;
            byte_class_reg   <= '0;
            line_done_reg    <= 1'b0;
            method_code_reg  <= '0;
            version_code_reg <= '0;
            line_ok_reg      <= 1'b0;
            url_length_reg   <= '0;
            path_length_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (line_last)
                begin
                    // end of line: start the next one from scratch
                    phase_reg        <= PHASE_METHOD;
                    method_pos_reg   <= '0;
                    method_cand_reg  <= '1;
                    in_query_reg     <= 1'b0;
                    url_count_reg    <= '0;
                    path_count_reg   <= '0;
                    version_pos_reg  <= '0;
                    version_cand_reg <= '1;
                end
                else
                begin
                    phase_reg        <= phase_next;
                    method_pos_reg   <= method_pos_next;
                    method_cand_reg  <= method_cand_next;
                    in_query_reg     <= in_query_next;
                    url_count_reg    <= url_count_next;
                    path_count_reg   <= path_count_next;
                    version_pos_reg  <= version_pos_next;
                    version_cand_reg <= version_cand_next;
                end
                result_valid_reg <= 1'b1;
                echo_byte_reg    <= line_byte;
                byte_class_reg   <= byte_class_next;
                line_done_reg    <= line_last;
                method_code_reg  <= method_code_next;
                version_code_reg <= version_code_next;
                line_ok_reg      <= line_ok_next;
                url_length_reg   <= url_length_next;
                path_length_reg  <= path_length_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign echo_byte    = echo_byte_reg;
    assign byte_class   = byte_class_reg;
    assign line_done    = line_done_reg;
    assign method_code  = method_code_reg;
    assign version_code = version_code_reg;
    assign line_ok      = line_ok_reg;
    assign url_length   = url_length_reg;
    assign path_length  = path_length_reg;

    // A held result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !line_ready)
        else $error("input accepted while result stalled");

    // A final byte produces a result marked done in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_ready && line_last) |=> (result_valid && line_done))
        else $error("final byte did not produce a done result");

    // line_ok needs both codes valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && line_ok) |->
            (method_code != METHOD_INVALID && version_code != VERSION_INVALID))
        else $error("line_ok with an invalid code");

    // Verdict fields stay zero away from the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !line_done) |->
            (method_code == METHOD_INVALID && !line_ok && url_length == 16'd0))
        else $error("verdict fields set on a non-final byte");

endmodule
